// ----- rtl/core/hwb_pkg.sv -----
// Shared types and constants of the weighted histogram binner.
`timescale 1ns / 1ps
package hwb_pkg;

  localparam int X_W    = 32;
  localparam int WT_W   = 32;
  localparam int SUM_W  = 48;
  localparam int ACC_W  = 64;
  localparam int WIN_W  = 40;
  localparam int GAP_W  = 33;
  localparam int BC_W   = 7;
  localparam int RW_W   = 16;
  localparam int BIN_W  = 6;
  localparam int DIV_DEN_W = 7;

  localparam logic [0:0] REG_BIN_COUNT      = 1'b0;
  localparam logic [0:0] REG_RELATIVE_WIDTH = 1'b1;

  localparam logic [BC_W-1:0] BC_RESET = 7'd0;
  localparam logic [RW_W-1:0] RW_RESET = 16'hFFFF;

  localparam logic signed [X_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [X_W-1:0] MAX_RESET = 32'sh8000_0000;

  // One point travelling down the row of bin cells
  typedef struct packed {
    logic                   valid;
    logic signed [X_W-1:0]  x;
    logic signed [WT_W-1:0] wt;
  } point_t;

  // Acceptance window and left edge of one bin, doubled scale for the window
  typedef struct packed {
    logic signed [WIN_W-1:0] lo2;
    logic signed [WIN_W-1:0] hi2;
    logic signed [WIN_W-1:0] left;
  } win_t;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_DIV   = 6'b000010,
    S_MUL   = 6'b000100,
    S_SETUP = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

// ----- rtl/core/hwb_point_if.sv -----
// Point input channel: valid/ready handshake with the point payload.
`timescale 1ns / 1ps
interface hwb_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_position;
  logic signed [31:0] weight;
  logic               last_point;

  modport source (output valid, x_position, weight, last_point, input ready);
  modport sink (input valid, x_position, weight, last_point, output ready);
endinterface

// ----- rtl/core/hwb_record_if.sv -----
// Bin record output channel: valid/ready handshake with the record payload.
`timescale 1ns / 1ps
interface hwb_record_if;
  logic               valid;
  logic               ready;
  logic [5:0]         bin_number;
  logic signed [31:0] left_edge;
  logic signed [31:0] right_edge;
  logic signed [47:0] bin_sum;
  logic               error_flag;
  logic               last_bin;

  modport source (output valid, bin_number, left_edge, right_edge, bin_sum, error_flag,
                  last_bin, input ready);
  modport sink (input valid, bin_number, left_edge, right_edge, bin_sum, error_flag,
                last_bin, output ready);
endinterface

// ----- rtl/core/hwb_div.sv -----
// Restoring divider: bin gap from the value span, one quotient bit per cycle.
`timescale 1ns / 1ps
module hwb_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [hwb_pkg::GAP_W-1:0]      dividend,
  input  logic [hwb_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                           done,
  output logic [hwb_pkg::GAP_W-1:0]      quotient
);
  import hwb_pkg::*;

  logic [GAP_W-1:0]     quo;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem;
  logic [5:0]           steps;
  logic                 busy;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem[DIV_DEN_W-1:0], quo[GAP_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 6'd1;
        if (steps == 6'(GAP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, den} : rem_sh;
      quo <= {quo[GAP_W-2:0], fits};
    end
  end

  assign quotient = quo;
endmodule

// ----- rtl/core/hwb_cell.sv -----
// One bin cell: holds a bin window, sums matching points, passes points on.
`timescale 1ns / 1ps
module hwb_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  hwb_pkg::win_t                       win_in,
  input  hwb_pkg::point_t                     pt_in,
  output hwb_pkg::point_t                     pt_out,
  output logic signed [hwb_pkg::ACC_W-1:0]    acc,
  output logic signed [hwb_pkg::WIN_W-1:0]    left
);
  import hwb_pkg::*;

  win_t                    win;
  logic signed [WIN_W-1:0] x2;
  logic                    hit;

  // Window test at doubled scale
  assign x2  = WIN_W'(pt_in.x) <<< 1;
  assign hit = pt_in.valid && (x2 >= win.lo2) && (x2 < win.hi2);

  // Hand the point to the neighbor, accumulate on a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else begin
      pt_out.valid <= pt_in.valid;
    end
    pt_out.x  <= pt_in.x;
    pt_out.wt <= pt_in.wt;
    if (load) begin
      win <= win_in;
      acc <= '0;
    end else if (hit) begin
      acc <= acc + ACC_W'(pt_in.wt);
    end
  end

  assign left = win.left;
endmodule

// ----- rtl/core/weighted_histogram_binner.sv -----
// Top level of the weighted histogram binner: point store, control and row of bin cells.
// Loading: one point per cycle, one point accepted per cycle while idle.
// After the last point: divide, multiply, set up n bins, scan the stored points, then
// n records at one per cycle unless stalled (an error run gives one record right away).
// The scan length is set by streaming every stored point through the row of bin cells.
// Reset (synchronous, rst high) empties the point set and resets both registers.
`timescale 1ns / 1ps
module weighted_histogram_binner #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_BINS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  hwb_point_if.sink   pt,
  hwb_record_if.source rec
);
  import hwb_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SCAN_W = $clog2(MAX_POINTS + MAX_BINS + 4);

  // Configuration registers
  logic [BC_W-1:0] bin_count;
  logic [RW_W-1:0] relative_width;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RELATIVE_WIDTH) ? {16'b0, relative_width}
                                                   : {25'b0, bin_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count      <= BC_RESET;
      relative_width <= RW_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BIN_COUNT:      bin_count <= pwdata[BC_W-1:0];
        REG_RELATIVE_WIDTH: relative_width <= pwdata[RW_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                  state;
  logic [CNT_W-1:0]        point_count;
  logic signed [X_W-1:0]   running_min;
  logic signed [X_W-1:0]   running_max;
  logic [BC_W-1:0]         n_run;
  logic                    err_run;
  logic [GAP_W-1:0]        gap;
  logic [GAP_W-1:0]        width;
  logic [IDX_W-1:0]        setup_idx;
  logic signed [WIN_W-1:0] left_acc;
  logic [SCAN_W-1:0]       scan_cnt;
  logic [IDX_W-1:0]        emit_idx;

  logic                    accept;
  logic                    has_room;
  logic [BC_W-1:0]         n_clamped;
  logic                    div_done;
  logic [GAP_W-1:0]        div_quo;
  logic                    div_start;
  logic                    emit_take;
  logic                    emit_last;
  logic                    setup_last;
  logic                    scan_end;

  assign pt.ready  = (state == S_LOAD);
  assign accept    = pt.valid && pt.ready;
  assign has_room  = point_count < CNT_W'(MAX_POINTS);
  assign n_clamped = (bin_count > BC_W'(MAX_BINS)) ? BC_W'(MAX_BINS) : bin_count;
  assign div_start = accept && pt.last_point && (bin_count >= BC_W'(2));

  // Point store
  logic signed [X_W-1:0]  pos_mem [MAX_POINTS];
  logic signed [WT_W-1:0] wt_mem  [MAX_POINTS];
  point_t                 rd_pt;
  logic                   rd_en;

  assign rd_en = (state == S_SCAN) && (scan_cnt < SCAN_W'(point_count));

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      pos_mem[point_count[ADDR_W-1:0]] <= pt.x_position;
      wt_mem[point_count[ADDR_W-1:0]]  <= pt.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pt.valid <= 1'b0;
    end else begin
      rd_pt.valid <= rd_en;
    end
    rd_pt.x  <= pos_mem[scan_cnt[ADDR_W-1:0]];
    rd_pt.wt <= wt_mem[scan_cnt[ADDR_W-1:0]];
  end

  function automatic logic [GAP_W-1:0] running_max_next_span();
    logic signed [X_W-1:0] mn;
    logic signed [X_W-1:0] mx;
    mn = running_min;
    mx = running_max;
    if (has_room && pt.x_position < mn) mn = pt.x_position;
    if (has_room && pt.x_position > mx) mx = pt.x_position;
    return GAP_W'($signed({mx[X_W-1], mx}) - $signed({mn[X_W-1], mn}));
  endfunction

  // Gap divider
  hwb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (GAP_W'(running_max_next_span())),
    .divisor  (n_clamped - BC_W'(1)),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Window of the bin being set up
  win_t                    setup_win;
  logic signed [WIN_W-1:0] lo_base;

  assign lo_base       = (left_acc <<< 1) + $signed({{(WIN_W-GAP_W){1'b0}}, width});
  assign setup_win.lo2 = lo_base - $signed({{(WIN_W-GAP_W){1'b0}}, gap});
  assign setup_win.hi2 = lo_base + $signed({{(WIN_W-GAP_W){1'b0}}, gap});
  assign setup_win.left = left_acc;
  assign setup_last    = ({1'b0, setup_idx} == (BC_W'(setup_idx) + BC_W'(0)))
                         && (BC_W'(setup_idx) + BC_W'(1) == n_run);
  assign scan_end      = scan_cnt == (SCAN_W'(point_count) + SCAN_W'(MAX_BINS + 2));

  // Row of bin cells
  point_t                  cell_pt   [MAX_BINS + 1];
  logic signed [ACC_W-1:0] cell_acc  [MAX_BINS];
  logic signed [WIN_W-1:0] cell_left [MAX_BINS];

  assign cell_pt[0] = rd_pt;

  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    hwb_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .load   ((state == S_SETUP) && (setup_idx == IDX_W'(k))),
      .win_in (setup_win),
      .pt_in  (cell_pt[k]),
      .pt_out (cell_pt[k+1]),
      .acc    (cell_acc[k]),
      .left   (cell_left[k])
    );
  end

  // Record selection and saturation
  logic signed [WIN_W-1:0] sel_left;
  logic signed [WIN_W-1:0] sel_right;
  logic signed [ACC_W-1:0] sel_acc;
  logic signed [SUM_W-1:0] sel_sum;

  assign sel_left  = cell_left[emit_idx];
  assign sel_acc   = cell_acc[emit_idx];
  assign sel_right = sel_left + $signed({{(WIN_W-GAP_W){1'b0}}, width});
  assign emit_take = (state == S_EMIT) && (!rec.valid || rec.ready);
  assign emit_last = err_run || (BC_W'(emit_idx) + BC_W'(1) == n_run);

  always_comb begin
    if (sel_acc > ACC_W'(48'sh7FFF_FFFF_FFFF)) begin
      sel_sum = 48'sh7FFF_FFFF_FFFF;
    end else if (sel_acc < -(ACC_W'(48'sh7FFF_FFFF_FFFF)) - ACC_W'(1)) begin
      sel_sum = 48'sh8000_0000_0000;
    end else begin
      sel_sum = sel_acc[SUM_W-1:0];
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      point_count <= '0;
      running_min <= MIN_RESET;
      running_max <= MAX_RESET;
      err_run     <= 1'b0;
      rec.valid   <= 1'b0;
    end else begin
      // Raise the record flag on a take, drop it once the request is taken
      if (emit_take) begin
        rec.valid <= 1'b1;
      end else if (rec.ready) begin
        rec.valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              point_count <= point_count + CNT_W'(1);
              if (pt.x_position < running_min) running_min <= pt.x_position;
              if (pt.x_position > running_max) running_max <= pt.x_position;
            end
            if (pt.last_point) begin
              err_run <= bin_count < BC_W'(2);
              state   <= (bin_count < BC_W'(2)) ? S_EMIT : S_DIV;
            end
          end
        end
        S_DIV: if (div_done) state <= S_MUL;
        S_MUL: state <= S_SETUP;
        S_SETUP: if (setup_last) state <= S_SCAN;
        S_SCAN: if (scan_end) state <= S_EMIT;
        S_EMIT: begin
          if (emit_take && emit_last) begin
            state       <= S_LOAD;
            point_count <= '0;
            running_min <= MIN_RESET;
            running_max <= MAX_RESET;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Datapath registers of the run
  always_ff @(posedge clk) begin
    if (accept && pt.last_point) begin
      n_run <= n_clamped;
    end
    if (div_done) begin
      gap <= div_quo;
    end
    if (state == S_MUL) begin
      width    <= GAP_W'(({16'b0, gap} * {33'b0, relative_width}) >> 16);
      left_acc <= WIN_W'(running_min);
    end
    if (state == S_MUL) begin
      setup_idx <= '0;
    end else if (state == S_SETUP) begin
      setup_idx <= setup_idx + IDX_W'(1);
      left_acc  <= left_acc + $signed({{(WIN_W-GAP_W){1'b0}}, gap});
    end
    if (state == S_SETUP) begin
      scan_cnt <= '0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end
    if (state != S_EMIT) begin
      emit_idx <= '0;
    end else if (emit_take) begin
      emit_idx <= emit_idx + IDX_W'(1);
    end
  end

  // Output record register
  always_ff @(posedge clk) begin
    if (emit_take) begin
      rec.error_flag <= err_run;
      rec.last_bin   <= emit_last;
      if (err_run) begin
        rec.bin_number <= '0;
        rec.left_edge  <= '0;
        rec.right_edge <= '0;
        rec.bin_sum    <= '0;
      end else begin
        rec.bin_number <= BIN_W'(emit_idx);
        rec.left_edge  <= sel_left[X_W-1:0];
        rec.right_edge <= (sel_right > WIN_W'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : sel_right[X_W-1:0];
        rec.bin_sum    <= sel_sum;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rec.valid && rec.error_flag |-> rec.last_bin && (rec.bin_number == '0))
    else $error("error record malformed");

  a_scan_bins: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (n_run >= BC_W'(2)) && !err_run)
    else $error("scan with too few bins");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && emit_take && emit_last |=> pt.ready)
    else $error("not back to loading after last record");
`endif
endmodule

// ----- tb/tb_binner_scoreboard.sv -----
// Bin record predictor and scoreboard for the weighted histogram binner.
`timescale 1ns / 1ps
class binner_scoreboard;
  localparam int POINT_DEPTH = 1024;
  localparam int BIN_LIMIT = 64;

  typedef struct packed {
    logic [5:0]         bin_number;
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
    logic signed [47:0] bin_sum;
    logic               error_flag;
    logic               last_bin;
  } record_t;

  logic signed [31:0] positions [POINT_DEPTH];
  logic signed [31:0] weights [POINT_DEPTH];
  int unsigned        count;
  logic signed [31:0] lowest;
  logic signed [31:0] highest;
  logic [6:0]         bin_count;
  logic [15:0]        rel_width;
  record_t            pending_records[$];
  int                 mismatches;

  function new();
    count = 0;
    lowest = 32'sh7FFF_FFFF;
    highest = 32'sh8000_0000;
    bin_count = 7'd0;
    rel_width = 16'hFFFF;
    mismatches = 0;
  endfunction

  // Store a point and, on the last one, predict every bin record
  function void note_point(logic signed [31:0] x, logic signed [31:0] wt, logic last);
    int unsigned n;
    longint unsigned gap, width;
    longint left, right, lo2, hi2, sum;
    record_t r;
    if (count < POINT_DEPTH) begin
      positions[count] = x;
      weights[count] = wt;
      count++;
      if (x < lowest) lowest = x;
      if (x > highest) highest = x;
    end
    if (!last) return;
    n = bin_count;
    if (n < 2) begin
      r = '0;
      r.error_flag = 1'b1;
      r.last_bin = 1'b1;
      pending_records = {pending_records, r};
    end else begin
      if (n > BIN_LIMIT) n = BIN_LIMIT;
      gap = longint'(longint'(highest) - longint'(lowest)) / (n - 1);
      width = (gap * rel_width) >> 16;
      for (int unsigned i = 0; i < n; i++) begin
        left = longint'(lowest) + longint'(i * gap);
        right = left + longint'(width);
        lo2 = 2 * left + longint'(width) - longint'(gap);
        hi2 = 2 * left + longint'(width) + longint'(gap);
        sum = 0;
        for (int unsigned j = 0; j < count; j++)
          if (2 * longint'(positions[j]) >= lo2 && 2 * longint'(positions[j]) < hi2)
            sum += longint'(weights[j]);
        if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
        if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
        if (right > 64'sh7FFF_FFFF) right = 64'sh7FFF_FFFF;
        r.bin_number = i[5:0];
        r.left_edge = left[31:0];
        r.right_edge = right[31:0];
        r.bin_sum = sum[47:0];
        r.error_flag = 1'b0;
        r.last_bin = (i + 1 == n);
        pending_records = {pending_records, r};
      end
    end
    count = 0;
    lowest = 32'sh7FFF_FFFF;
    highest = 32'sh8000_0000;
  endfunction

  // Compare one emitted record with the oldest prediction
  function void check_record(record_t got);
    record_t want;
    if (pending_records.size() == 0) begin
      $display("%0t: unexpected record, got %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_records.pop_front();
    if (got.bin_number !== want.bin_number || got.left_edge !== want.left_edge ||
        got.right_edge !== want.right_edge || got.bin_sum !== want.bin_sum ||
        got.error_flag !== want.error_flag || got.last_bin !== want.last_bin) begin
      $display("%0t: record mismatch, expected bin %0d l %h r %h s %h e %b z %b",
               $time, want.bin_number, want.left_edge, want.right_edge, want.bin_sum,
               want.error_flag, want.last_bin);
      $display("%0t:                  actual bin %0d l %h r %h s %h e %b z %b",
               $time, got.bin_number, got.left_edge, got.right_edge, got.bin_sum,
               got.error_flag, got.last_bin);
      mismatches++;
    end
  endfunction
endclass

// ----- tb/tb.sv -----
// Top-level testbench of the weighted histogram binner.
`timescale 1ns / 1ps
module tb;
  import hwb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;

  hwb_point_if  pt ();
  hwb_record_if rec ();

  binner_scoreboard board = new();

  weighted_histogram_binner dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pt(pt.sink), .rec(rec.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive record ready at random, unless held off
  always @(posedge clk) begin
    if (rst || hold_off) rec.ready <= 1'b0;
    else rec.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check records and watch for a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (rec.valid && rec.ready)
        board.check_record({rec.bin_number, rec.left_edge, rec.right_edge, rec.bin_sum,
                            rec.error_flag, rec.last_bin});
      if ((rec.valid && rec.ready) || (pt.valid && pt.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("weighted_histogram_binner regression: fail");
        $finish;
      end
    end
  end

  // Write one register through the setup and access cycles
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BIN_COUNT) board.bin_count = value[6:0];
    else board.rel_width = value[15:0];
  endtask

  // Offer one point and hold it until accepted
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] wt, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk);
    end
    pt.valid <= 1'b1;
    pt.x_position <= x;
    pt.weight <= wt;
    pt.last_point <= last;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    board.note_point(x, wt, last);
  endtask

  task automatic end_offer();
    pt.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every record has arrived, then let the block settle
  task automatic drain();
    end_offer();
    while (board.pending_records.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_x();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(255) << 12;
    endcase
  endfunction

  function automatic logic [31:0] rand_wt();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  // Send a random set of points of the given size
  task automatic send_set(int size);
    for (int k = 0; k < size; k++) send_point(rand_x(), rand_wt(), k == size - 1);
  endtask

  initial begin
    int sent;
    pt.valid <= 1'b0;
    pt.x_position <= '0;
    pt.weight <= '0;
    pt.last_point <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: error run at reset bin count, then extremes
    send_point(32'sh0001_0000, 32'sh0001_0000, 1'b1);
    drain();
    write_reg(REG_BIN_COUNT, 32'd1);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    drain();
    write_reg(REG_BIN_COUNT, 32'd2);
    write_reg(REG_RELATIVE_WIDTH, 32'd0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh0000_0000, 32'sh8000_0000, 1'b1);
    drain();
    write_reg(REG_BIN_COUNT, 32'd127);
    write_reg(REG_RELATIVE_WIDTH, 32'hFFFF);
    for (int k = 0; k < 4; k++) send_point(32'sh0003_0000, 32'sh0000_8000, k == 3);
    drain();
    write_reg(REG_BIN_COUNT, 32'd5);
    write_reg(REG_RELATIVE_WIDTH, 32'h8000);
    for (int k = 0; k < 9; k++)
      send_point(32'(k) <<< 16, 32'(k) <<< 14, k == 8);
    drain();

    // Random sets under three idling mixes, registers changed between sets
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 12 : 0;
      for (int s = 0; s < 9; s++) begin
        int size;
        size = $urandom_range(1, 12);
        case ($urandom_range(5))
          0: write_reg(REG_BIN_COUNT, $urandom_range(1));
          1: write_reg(REG_BIN_COUNT, 64);
          default: write_reg(REG_BIN_COUNT, $urandom_range(127));
        endcase
        write_reg(REG_RELATIVE_WIDTH, $urandom_range(65535));
        send_set(size);
        sent += size;
        drain();
      end
    end

    // Hold off the receiver while sets keep coming, so the block backs up
    write_reg(REG_BIN_COUNT, 64);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_set(3);
        send_set(4);
      end
    join
    drain();
    send_idle_pct = 12;
    recv_idle_pct = 12;
    while (sent < 220) begin
      int size;
      size = $urandom_range(1, 15);
      write_reg(REG_BIN_COUNT, $urandom_range(2, 64));
      write_reg(REG_RELATIVE_WIDTH, $urandom);
      send_set(size);
      sent += size;
      drain();
    end

    if (board.mismatches == 0 && board.pending_records.size() == 0)
      $display("weighted_histogram_binner regression: pass");
    else
      $display("weighted_histogram_binner regression: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/hwb_pkg.sv
rtl/core/hwb_point_if.sv
rtl/core/hwb_record_if.sv
rtl/core/hwb_div.sv
rtl/core/hwb_cell.sv
rtl/core/weighted_histogram_binner.sv
tb/tb_binner_scoreboard.sv
tb/tb.sv
